// File: rtl/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg
// Shared constants and types of the echo prefix suppressor.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 64;
  localparam int BYTE_W            = 8;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // work handed from the front part to the back part; the replay length
  // travels next to it because its width follows the payload depth
  typedef struct packed {
    logic                is_status;
    logic                arm_ok;
    logic                armed;
    logic                has_tail;
    logic [BYTE_W-1:0]   tail_byte;
  } cmd_t;

endpackage

// File: rtl/eps_if.sv
// ----------------------------------------------------------------------------
// eps_in_if / eps_out_if
// Valid/ready channels of the echo prefix suppressor.
// ----------------------------------------------------------------------------
interface eps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_in;
  logic       payload_last;

  modport source (output valid, output op, output byte_in, output payload_last,
                  input ready);
  modport sink   (input valid, input op, input byte_in, input payload_last,
                  output ready);
endinterface

interface eps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic       arm_ok;
  logic       armed_now;
  logic       last;

  modport source (output valid, output out_byte, output is_status, output arm_ok,
                  output armed_now, output last, input ready);
  modport sink   (input valid, input out_byte, input is_status, input arm_ok,
                  input armed_now, input last, output ready);
endinterface

// File: rtl/echo_prefix_suppressor_core.sv
// ----------------------------------------------------------------------------
// echo_prefix_suppressor_core
// Swallows the expected echo of a sent payload from a byte stream.
//
//   channel  dir  fields                                       transfer
//   in_ch    in   op, byte_in, payload_last                    valid & ready
//   out_ch   out  out_byte, is_status, arm_ok, armed_now, last valid & ready
//
// data, load and flush transfers are taken one per cycle when no stall applies
// a replay of n held bytes reads them one byte a cycle from the second read
// port while the output stage accepts, then sends the byte that broke it, if any
// a load byte that writes the store waits until all queued work is done
// an armed data byte waits after a store write at its compare address
// rst_n is synchronous; the payload store has no reset and no clearing pass
// ----------------------------------------------------------------------------
module echo_prefix_suppressor_core #(
  parameter int PAYLOAD_DEPTH = eps_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  eps_in_if.sink    in_ch,
  eps_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
  localparam int IDX_W  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int WORK_W = $bits(eps_pkg::cmd_t) + CNT_W;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] cmp_addr;
  logic [7:0]       cmp_data;
  logic [IDX_W-1:0] rep_addr;
  logic [7:0]       rep_data;

  logic              push;
  eps_pkg::cmd_t     push_cmd;
  logic [CNT_W-1:0]  push_cnt;
  logic              pop;
  eps_pkg::cmd_t     pop_cmd;
  logic [CNT_W-1:0]  pop_cnt;
  logic [WORK_W-1:0] pop_work;
  logic              fifo_full;
  logic              fifo_empty;
  logic              back_idle;

  eps_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd0_addr (cmp_addr),
    .rd0_data (cmp_data),
    .rd1_addr (rep_addr),
    .rd1_data (rep_data)
  );

  eps_front #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (cmp_addr),
    .rd_data   (cmp_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_cnt  (push_cnt),
    .fifo_full (fifo_full),
    .back_idle (back_idle)
  );

  eps_cmd_fifo #(
    .WIDTH (WORK_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cmd, push_cnt}),
    .pop       (pop),
    .pop_data  (pop_work),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  assign pop_cmd = pop_work[WORK_W-1:CNT_W];
  assign pop_cnt = pop_work[CNT_W-1:0];

  eps_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (fifo_empty),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_cnt   (pop_cnt),
    .rd_addr   (rep_addr),
    .rd_data   (rep_data),
    .back_idle (back_idle),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/eps_ram.sv
// ----------------------------------------------------------------------------
// eps_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module eps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd0_addr,
  output logic [WIDTH-1:0]                       rd0_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd1_addr,
  output logic [WIDTH-1:0]                       rd1_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd0_q_r;
  logic [WIDTH-1:0] rd1_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd0_q_r <= mem_r[rd0_addr];
    rd1_q_r <= mem_r[rd1_addr];
  end

  assign rd0_data = rd0_q_r;
  assign rd1_data = rd1_q_r;

endmodule

// File: rtl/eps_front.sv
// ----------------------------------------------------------------------------
// eps_front
// Accepts input transfers, keeps arm/match/load state, writes the payload
// store and queues the output work for the back part.
// ----------------------------------------------------------------------------
module eps_front #(
  parameter int PAYLOAD_DEPTH = eps_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  eps_in_if.sink              in_ch,
  output logic                wr_en,
  output logic [((PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1)-1:0] wr_addr,
  output logic [7:0]          wr_data,
  output logic [((PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1)-1:0] rd_addr,
  input  logic [7:0]          rd_data,
  output logic                push,
  output eps_pkg::cmd_t       push_cmd,
  output logic [$clog2(PAYLOAD_DEPTH+1)-1:0] push_cnt,
  input  logic                fifo_full,
  input  logic                back_idle
);

  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
  localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PAYLOAD_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic             armed_r, armed_nxt;
  logic [CNT_W-1:0] match_cnt_r, match_cnt_nxt;
  logic [CNT_W-1:0] pay_len_r, pay_len_nxt;
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic             load_ovf_r, load_ovf_nxt;
  logic             fresh_r, fresh_nxt;

  logic room;
  logic hit;
  logic need_wr;
  logic fire;

  assign room    = (load_cnt_r != DEPTH_C);
  assign hit     = (match_cnt_r < pay_len_r) && (rd_data == in_ch.byte_in);
  assign need_wr = (in_ch.op == eps_pkg::OP_LOAD) && !armed_r && room;

  assign in_ch.ready = !fifo_full && !(need_wr && !back_idle) &&
                       !((in_ch.op == eps_pkg::OP_DATA) && armed_r && !fresh_r);
  assign fire = in_ch.valid && in_ch.ready;

  assign wr_en   = fire && need_wr;
  assign wr_addr = load_cnt_r[IDX_W-1:0];
  assign wr_data = in_ch.byte_in;
  assign rd_addr = match_cnt_nxt[IDX_W-1:0];

  always_comb begin
    logic             ok;
    logic             ovf_now;
    logic [CNT_W-1:0] cnt_now;
    ok            = 1'b0;
    ovf_now       = load_ovf_r | !room;
    cnt_now       = room ? (load_cnt_r + ONE_C) : load_cnt_r;
    armed_nxt     = armed_r;
    match_cnt_nxt = match_cnt_r;
    pay_len_nxt   = pay_len_r;
    load_cnt_nxt  = load_cnt_r;
    load_ovf_nxt  = load_ovf_r;
    push          = 1'b0;
    push_cnt      = '0;
    push_cmd      = '0;
    if (fire) begin
      case (in_ch.op)
        eps_pkg::OP_DATA: begin
          if (!armed_r) begin
            push               = 1'b1;
            push_cmd.has_tail  = 1'b1;
            push_cmd.tail_byte = in_ch.byte_in;
          end else if (hit) begin
            match_cnt_nxt = match_cnt_r + ONE_C;
            if ((match_cnt_r + ONE_C) >= pay_len_r) begin
              armed_nxt     = 1'b0;
              match_cnt_nxt = '0;
              pay_len_nxt   = '0;
            end
          end else begin
            push               = 1'b1;
            push_cnt           = match_cnt_r;
            push_cmd.has_tail  = 1'b1;
            push_cmd.tail_byte = in_ch.byte_in;
            armed_nxt          = 1'b0;
            match_cnt_nxt      = '0;
            pay_len_nxt        = '0;
          end
        end
        eps_pkg::OP_LOAD: begin
          load_cnt_nxt = cnt_now;
          load_ovf_nxt = ovf_now;
          if (in_ch.payload_last) begin
            ok = !armed_r && !ovf_now && (cnt_now != '0);
            if (ok) begin
              pay_len_nxt   = cnt_now;
              match_cnt_nxt = '0;
              armed_nxt     = 1'b1;
            end
            load_cnt_nxt       = '0;
            load_ovf_nxt       = 1'b0;
            push               = 1'b1;
            push_cmd.is_status = 1'b1;
            push_cmd.arm_ok    = ok;
            push_cmd.armed     = armed_r | ok;
          end
        end
        eps_pkg::OP_FLUSH: begin
          if (armed_r && (match_cnt_r != '0)) begin
            push     = 1'b1;
            push_cnt = match_cnt_r;
          end
          armed_nxt     = 1'b0;
          match_cnt_nxt = '0;
          pay_len_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // compare data is usable unless the store was written at the address read
  assign fresh_nxt = !(wr_en && (wr_addr == match_cnt_nxt[IDX_W-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      match_cnt_r <= '0;
      pay_len_r   <= '0;
      load_cnt_r  <= '0;
      load_ovf_r  <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      match_cnt_r <= match_cnt_nxt;
      pay_len_r   <= pay_len_nxt;
      load_cnt_r  <= load_cnt_nxt;
      load_ovf_r  <= load_ovf_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_during_replay: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> back_idle)
    else $error("payload store written while replay pending");

  a_match_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (match_cnt_r < pay_len_r))
    else $error("match count reached payload length while armed");

  a_disarmed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> ((match_cnt_r == '0) && (pay_len_r == '0)))
    else $error("stale match state while disarmed");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("work queue overrun");
`endif

endmodule

// File: rtl/eps_cmd_fifo.sv
// ----------------------------------------------------------------------------
// eps_cmd_fifo
// Two-entry queue of work items between the front and back parts.
// ----------------------------------------------------------------------------
module eps_cmd_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/eps_back.sv
// ----------------------------------------------------------------------------
// eps_back
// Executes queued work: status, pass-through byte, replay of the held prefix
// from the payload store, into a registered output stage.
// ----------------------------------------------------------------------------
module eps_back #(
  parameter int PAYLOAD_DEPTH = eps_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  output logic                pop,
  input  eps_pkg::cmd_t       pop_cmd,
  input  logic [$clog2(PAYLOAD_DEPTH+1)-1:0] pop_cnt,
  output logic [((PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1)-1:0] rd_addr,
  input  logic [7:0]          rd_data,
  output logic                back_idle,
  eps_out_if.source           out_ch
);

  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
  localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REPLAY = 2'd1;
  localparam logic [1:0] ST_TAIL   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             has_tail_r, has_tail_nxt;
  logic [7:0]       tail_r, tail_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             status_r, status_nxt;
  logic             ok_r, ok_nxt;
  logic             armed_r, armed_nxt;
  logic             last_r, last_nxt;

  logic can_load;
  logic load;
  logic at_end;

  assign can_load  = !out_valid_r || out_ch.ready;
  assign at_end    = ((idx_r + ONE_C) == cnt_r);
  assign back_idle = (state_r == ST_IDLE) && empty;
  assign rd_addr   = idx_nxt[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    has_tail_nxt = has_tail_r;
    tail_nxt     = tail_r;
    pop          = 1'b0;
    load         = 1'b0;
    byte_nxt     = byte_r;
    status_nxt   = status_r;
    ok_nxt       = ok_r;
    armed_nxt    = armed_r;
    last_nxt     = last_r;
    case (state_r)
      ST_IDLE: begin
        if (!empty && can_load) begin
          pop = 1'b1;
          if (pop_cnt == '0) begin
            load       = 1'b1;
            byte_nxt   = pop_cmd.is_status ? 8'd0 : pop_cmd.tail_byte;
            status_nxt = pop_cmd.is_status;
            ok_nxt     = pop_cmd.arm_ok;
            armed_nxt  = pop_cmd.armed;
            last_nxt   = 1'b1;
          end else begin
            state_nxt    = ST_REPLAY;
            idx_nxt      = '0;
            cnt_nxt      = pop_cnt;
            has_tail_nxt = pop_cmd.has_tail;
            tail_nxt     = pop_cmd.tail_byte;
          end
        end
      end
      ST_REPLAY: begin
        if (can_load) begin
          load       = 1'b1;
          byte_nxt   = rd_data;
          status_nxt = 1'b0;
          ok_nxt     = 1'b0;
          armed_nxt  = 1'b0;
          last_nxt   = at_end && !has_tail_r;
          idx_nxt    = idx_r + ONE_C;
          if (at_end) begin
            state_nxt = has_tail_r ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (can_load) begin
          load       = 1'b1;
          byte_nxt   = tail_r;
          status_nxt = 1'b0;
          ok_nxt     = 1'b0;
          armed_nxt  = 1'b0;
          last_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    has_tail_r <= has_tail_nxt;
    tail_r     <= tail_nxt;
    byte_r     <= byte_nxt;
    status_r   <= status_nxt;
    ok_r       <= ok_nxt;
    armed_r    <= armed_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.is_status = status_r;
  assign out_ch.arm_ok    = ok_r;
  assign out_ch.armed_now = armed_r;
  assign out_ch.last      = last_r;

`ifndef NO_ASSERTIONS
  a_replay_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLAY) |-> (idx_r < cnt_r))
    else $error("replay index past held prefix");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (can_load && !empty && (state_r == ST_IDLE)))
    else $error("work popped without output slot");
`endif

endmodule
